### rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way merge block
// Sizes, opcode and status codes, controller states and the structs
// broadcast to, or passed along, the row of run cells.
// ----------------------------------------------------------------------------
package kwm_pkg;

	// Geometry
	localparam int CHUNKS      = 8;
	localparam int CHUNK_DEPTH = 256;

	// Field widths
	localparam int VAL_W  = 32;
	localparam int OP_W   = 2;
	localparam int CID_W  = 3;
	localparam int ST_W   = 2;
	localparam int CCNT_W = 4;

	// Derived widths
	localparam int IDX_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int CMP_W  = (IDX_W > CID_W) ? IDX_W : CID_W;
	localparam int ADDR_W = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int PTR_W  = $clog2(CHUNK_DEPTH + 1);

	// Opcodes
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_REFUSED   = 2'd1;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Append request broadcast to every cell
	typedef struct packed {
		logic                    valid;
		logic [CID_W-1:0]        id;
		logic signed [VAL_W-1:0] value;
	} wr_t;

	// Read-position advance broadcast to every cell
	typedef struct packed {
		logic             valid;
		logic [CMP_W-1:0] idx;
	} adv_t;

	// Running minimum handed from one cell to the next
	typedef struct packed {
		logic                    tok;
		logic                    found;
		logic [CMP_W-1:0]        idx;
		logic signed [VAL_W-1:0] val;
	} carry_t;

endpackage

### rtl/kwm_if.sv
// ----------------------------------------------------------------------------
// kwm_if: request and response channels of the k-way merge block
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface kwm_req_if;
	import kwm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic [CID_W-1:0]        chunk_id;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, op, chunk_id, value, input ready);
	modport sink   (input valid, op, chunk_id, value, output ready);
endinterface

interface kwm_rsp_if;
	import kwm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic [CID_W-1:0]        source_chunk;
	logic [ST_W-1:0]         status;

	modport source (output valid, out_value, source_chunk, status, input ready);
	modport sink   (input valid, out_value, source_chunk, status, output ready);
endinterface

### rtl/k_way_merge_of_sorted_runs.sv
// ----------------------------------------------------------------------------
// k_way_merge_of_sorted_runs: merge of up to CHUNKS sorted runs
// Appends values to runs and returns the smallest head on each take.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, chunk_id, value
//   rsp      out  valid/ready   out_value, source_chunk, status
//   cfg      in   cfg_we        cfg_wdata (chunk_count)
//
// A take holds off the next request until its scan is done; the scan token
// visits one run cell per cycle down the row of cells.
// Clear, append and unused ops skip the scan and go straight to done.
// A request is accepted while a finished response waits in the output
// register; the next result holds until that response is taken.
// Reset clears all fill counts and read positions; element storage is not
// cleared.
// ----------------------------------------------------------------------------
module k_way_merge_of_sorted_runs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [kwm_pkg::CCNT_W-1:0] cfg_wdata,
	kwm_req_if.sink                    req,
	kwm_rsp_if.source                  rsp
);
	import kwm_pkg::*;

	state_t                  state_q;
	state_t                  state_d;
	logic [CCNT_W-1:0]       chunk_count_q;
	logic [CHUNKS-1:0]       active;
	logic [CHUNKS-1:0]       can_append;
	logic                    req_acc;
	logic                    clr;
	wr_t                     wr;
	adv_t                    adv;
	carry_t                  carry [CHUNKS+1];

	logic                    load_res;
	logic signed [VAL_W-1:0] res_value_d;
	logic [CID_W-1:0]        res_src_d;
	logic [ST_W-1:0]         res_status_d;
	logic signed [VAL_W-1:0] res_value_q;
	logic [CID_W-1:0]        res_src_q;
	logic [ST_W-1:0]         res_status_q;

	logic                    load_rsp;
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] rsp_value_q;
	logic [CID_W-1:0]        rsp_src_q;
	logic [ST_W-1:0]         rsp_status_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= CCNT_W'(1);
		end else if (cfg_we) begin
			chunk_count_q <= cfg_wdata;
		end
	end

	// Runs taking part in the merge
	always_comb begin
		for (int c = 0; c < CHUNKS; c++) begin
			active[c] = (32'(chunk_count_q) > 32'(c));
		end
	end

	// Request handshake and broadcasts
	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign clr       = req_acc && (req.op == OP_CLEAR);
	assign wr.valid  = req_acc && (req.op == OP_APPEND);
	assign wr.id     = req.chunk_id;
	assign wr.value  = req.value;

	// Inject the scan token into the first cell
	assign carry[0].tok   = req_acc && (req.op == OP_TAKE);
	assign carry[0].found = 1'b0;
	assign carry[0].idx   = '0;
	assign carry[0].val   = '0;

	// Row of run cells
	for (genvar g = 0; g < CHUNKS; g++) begin : g_cell
		kwm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.my_idx     (CMP_W'(g)),
			.active     (active[g]),
			.clr        (clr),
			.wr         (wr),
			.adv        (adv),
			.carry_in   (carry[g]),
			.carry_out  (carry[g+1]),
			.can_append (can_append[g])
		);
	end

	// Controller: next state, result and advance
	always_comb begin
		state_d      = state_q;
		load_res     = 1'b0;
		load_rsp     = 1'b0;
		res_value_d  = '0;
		res_src_d    = '0;
		res_status_d = ST_OK;
		adv          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req.op == OP_TAKE) begin
						state_d = S_SCAN;
					end else begin
						state_d  = S_DONE;
						load_res = 1'b1;
						if ((req.op == OP_APPEND) && !(|can_append)) begin
							res_status_d = ST_REFUSED;
						end
					end
				end
			end
			S_SCAN: begin
				if (carry[CHUNKS].tok) begin
					state_d  = S_DONE;
					load_res = 1'b1;
					if (carry[CHUNKS].found) begin
						res_value_d = carry[CHUNKS].val;
						res_src_d   = carry[CHUNKS].idx[CID_W-1:0];
						adv.valid   = 1'b1;
						adv.idx     = carry[CHUNKS].idx;
					end else begin
						res_status_d = ST_EXHAUSTED;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the finished result
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_value_q  <= res_value_d;
			res_src_q    <= res_src_d;
			res_status_q <= res_status_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_value_q  <= res_value_q;
			rsp_src_q    <= res_src_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_value    = rsp_value_q;
	assign rsp.source_chunk = rsp_src_q;
	assign rsp.status       = rsp_status_q;

`ifndef SYNTHESIS
	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		carry[CHUNKS].tok |-> (state_q == S_SCAN))
		else $error("scan token left the row outside a scan");

	a_take_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.op == OP_TAKE)) |=> (state_q == S_SCAN))
		else $error("accepted take did not start a scan");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && rsp_valid_q && !rsp.ready) |=> (state_q == S_DONE))
		else $error("result dropped while output register was full");
`endif

endmodule

### rtl/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, then register the read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/kwm_cell.sv
// ----------------------------------------------------------------------------
// kwm_cell: one run of the merge
// Holds the run's elements, fill count and read position, and folds its
// head into the running minimum passed down the row of cells.
// ----------------------------------------------------------------------------
module kwm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [kwm_pkg::CMP_W-1:0] my_idx,
	input  logic                      active,
	input  logic                      clr,
	input  kwm_pkg::wr_t              wr,
	input  kwm_pkg::adv_t             adv,
	input  kwm_pkg::carry_t           carry_in,
	output kwm_pkg::carry_t           carry_out,
	output logic                      can_append
);
	import kwm_pkg::*;

	logic [PTR_W-1:0]        fill_q;
	logic [PTR_W-1:0]        rd_q;
	logic signed [VAL_W-1:0] head;
	logic                    do_write;
	logic                    do_adv;
	logic                    has_head;
	logic                    better;
	carry_t                  carry_q;

	// Decode the append request for this run
	assign can_append = (CMP_W'(wr.id) == my_idx) && active &&
	                    (fill_q < PTR_W'(CHUNK_DEPTH));
	assign do_write   = wr.valid && can_append;
	assign do_adv     = adv.valid && (adv.idx == my_idx);

	// Advance fill count and read position; drop both on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_q   <= '0;
		end else if (clr) begin
			fill_q <= '0;
			rd_q   <= '0;
		end else begin
			if (do_write) begin
				fill_q <= fill_q + PTR_W'(1);
			end
			if (do_adv) begin
				rd_q <= rd_q + PTR_W'(1);
			end
		end
	end

	// Element storage; the registered read port shows the head at the read position
	kwm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CHUNK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (wr.value),
		.raddr (rd_q[ADDR_W-1:0]),
		.rdata (head)
	);

	// Compare the head against the running minimum; ties keep the lower run
	assign has_head = active && (rd_q < fill_q);
	assign better   = has_head && (!carry_in.found || (head < carry_in.val));

	// Pass the scan token and hold the running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q.tok <= carry_in.tok;
			if (better) begin
				carry_q.found <= 1'b1;
				carry_q.idx   <= my_idx;
				carry_q.val   <= head;
			end else begin
				carry_q.found <= carry_in.found;
				carry_q.idx   <= carry_in.idx;
				carry_q.val   <= carry_in.val;
			end
		end
	end

	assign carry_out = carry_q;

`ifndef SYNTHESIS
	a_rd_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= fill_q)
		else $error("read position passed fill count");

	a_fill_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PTR_W'(CHUNK_DEPTH))
		else $error("fill count beyond run depth");

	a_adv_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		do_adv |-> (rd_q < fill_q))
		else $error("advance on an exhausted run");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the k-way merge of sorted runs
// Drives clear, append and take requests into the merge block, predicts every
// response with its own copy of the runs, read positions and run count, and
// checks each response field by field. Directed cases come first, then
// back-pressure and random merge rounds under shifting idle patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kwm_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam int              CYCLE_LIMIT = 500_000;
	localparam int              SHOW_LIMIT  = 10;
	localparam int              SCAN_CYCLES = CHUNKS + 3;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [CID_W-1:0]        src;
		logic [ST_W-1:0]         status;
	} merge_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CCNT_W-1:0] cfg_wdata;

	kwm_req_if req_ch ();
	kwm_rsp_if rsp_ch ();

	k_way_merge_of_sorted_runs dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the merge state
	logic signed [VAL_W-1:0] run_store [CHUNKS][CHUNK_DEPTH];
	int                      fill_level [CHUNKS];
	int                      take_pos   [CHUNKS];
	logic [CCNT_W-1:0]       run_count;

	merge_result_t pending_results [$];
	merge_result_t want;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int cycle_count = 0;
	int error_count = 0;
	int accepted_requests;
	int results_checked = 0;
	int merged_values;
	int refused_appends;
	int exhausted_takes;
	int count_writes;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Compute the response to one request and advance the shadow state
	function automatic merge_result_t predict_merge(input logic [OP_W-1:0] op,
			input logic [CID_W-1:0] id, input logic signed [VAL_W-1:0] val);
		merge_result_t           r;
		int unsigned             live;
		bit                      found;
		int                      best;
		logic signed [VAL_W-1:0] best_val;
		r        = '0;
		live     = (run_count < CHUNKS) ? run_count : CHUNKS;
		found    = 1'b0;
		best     = 0;
		best_val = '0;
		case (op)
			OP_CLEAR: begin
				for (int c = 0; c < CHUNKS; c++) begin
					fill_level[c] = 0;
					take_pos[c]   = 0;
				end
			end
			OP_APPEND: begin
				if (id >= live || fill_level[id] >= CHUNK_DEPTH) begin
					r.status = ST_REFUSED;
				end else begin
					run_store[id][fill_level[id]] = val;
					fill_level[id]++;
				end
			end
			OP_TAKE: begin
				// scan the heads; strict less-than keeps the lowest run on ties
				for (int c = 0; c < live; c++) begin
					if (take_pos[c] < fill_level[c]) begin
						if (!found || run_store[c][take_pos[c]] < best_val) begin
							found    = 1'b1;
							best     = c;
							best_val = run_store[c][take_pos[c]];
						end
					end
				end
				if (found) begin
					take_pos[best]++;
					r.value = best_val;
					r.src   = best[CID_W-1:0];
				end else begin
					r.status = ST_EXHAUSTED;
				end
			end
			default: begin
				// unused op: all-zero response, no state change
			end
		endcase
		return r;
	endfunction

	// Offer one request and record its expected response once accepted
	task automatic send_request(input logic [OP_W-1:0] op, input logic [CID_W-1:0] id,
			input logic signed [VAL_W-1:0] val);
		merge_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.chunk_id <= id;
		req_ch.value    <= val;
		do @(posedge clk); while (!req_ch.ready);
		r = predict_merge(op, id, val);
		pending_results.push_back(r);
		accepted_requests++;
		if (op == OP_TAKE && r.status == ST_OK)
			merged_values++;
		if (r.status == ST_REFUSED)
			refused_appends++;
		if (r.status == ST_EXHAUSTED)
			exhausted_takes++;
		@(negedge clk);
	endtask

	// Write the run count once the block has drained
	task automatic write_run_count(input logic [CCNT_W-1:0] cnt);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SCAN_CYCLES + 2) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cnt;
		run_count  = cnt;
		count_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Check each accepted response against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= SHOW_LIMIT)
					$display("tb: unexpected response value=%0d run=%0d status=%0d",
						rsp_ch.out_value, rsp_ch.source_chunk, rsp_ch.status);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (rsp_ch.out_value !== want.value || rsp_ch.source_chunk !== want.src ||
						rsp_ch.status !== want.status) begin
					error_count++;
					if (error_count <= SHOW_LIMIT)
						$display({"tb: mismatch at cycle %0d: expected value=%0d run=%0d ",
							"status=%0d, got value=%0d run=%0d status=%0d"},
							cycle_count, want.value, want.src, want.status,
							rsp_ch.out_value, rsp_ch.source_chunk, rsp_ch.status);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d responses outstanding",
				cycle_count, pending_results.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// Out of reset: one run takes part
	task automatic test_reset_state();
		send_request(OP_TAKE, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd1, 32'sd5);
		send_request(OP_APPEND, 3'd0, 32'sh7FFF_FFFF);
		send_request(OP_TAKE, 3'd0, 32'sd0);
		send_request(OP_TAKE, 3'd0, 32'sd0);
		send_request(OP_UNUSED, 3'd7, 32'shFFFF_FFFF);
	endtask

	// Field extremes, ties on equal heads, append after take
	task automatic test_extremes();
		write_run_count(4'd8);
		send_request(OP_CLEAR, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd0, 32'sh8000_0000);
		send_request(OP_APPEND, 3'd1, 32'sh7FFF_FFFF);
		send_request(OP_APPEND, 3'd2, -32'sd1);
		send_request(OP_APPEND, 3'd3, 32'sd0);
		send_request(OP_APPEND, 3'd4, 32'sd0);
		send_request(OP_APPEND, 3'd5, 32'sh5555_5555);
		send_request(OP_APPEND, 3'd6, 32'shAAAA_AAAA);
		send_request(OP_APPEND, 3'd7, 32'sd1);
		repeat (3) send_request(OP_TAKE, 3'd0, 32'sd0);
		// new head for run 0 after its first value is gone
		send_request(OP_APPEND, 3'd0, -32'sd7);
		repeat (7) send_request(OP_TAKE, 3'd0, 32'sd0);
		send_request(OP_UNUSED, 3'd2, 32'sh1234_5678);
	endtask

	// Zero runs, a count above CHUNKS, and a count lowered mid-merge
	task automatic test_run_count_edges();
		write_run_count(4'd0);
		send_request(OP_APPEND, 3'd0, 32'sd1);
		send_request(OP_TAKE, 3'd0, 32'sd0);
		write_run_count(4'd15);
		send_request(OP_CLEAR, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd7, 32'sd3);
		send_request(OP_APPEND, 3'd0, 32'sd9);
		repeat (3) send_request(OP_TAKE, 3'd0, 32'sd0);
		write_run_count(4'd4);
		send_request(OP_CLEAR, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd0, 32'sd10);
		send_request(OP_APPEND, 3'd1, 32'sd20);
		send_request(OP_APPEND, 3'd2, 32'sd5);
		send_request(OP_APPEND, 3'd3, 32'sd1);
		send_request(OP_TAKE, 3'd0, 32'sd0);
		// runs 2 and 3 keep their contents but drop out of the scan
		write_run_count(4'd2);
		send_request(OP_TAKE, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd3, 32'sd2);
		repeat (2) send_request(OP_TAKE, 3'd0, 32'sd0);
		write_run_count(4'd4);
		repeat (2) send_request(OP_TAKE, 3'd0, 32'sd0);
	endtask

	// Fill one run to the top; the next append is refused
	task automatic test_full_run();
		write_run_count(4'd1);
		send_request(OP_CLEAR, 3'd0, 32'sd0);
		for (int i = 0; i <= CHUNK_DEPTH; i++)
			send_request(OP_APPEND, 3'd0, 32'(i * 3 - 300));
		repeat (5) send_request(OP_TAKE, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd0, 32'sd1000);
		send_request(OP_CLEAR, 3'd0, 32'sd0);
		send_request(OP_APPEND, 3'd0, -32'sd42);
		repeat (2) send_request(OP_TAKE, 3'd0, 32'sd0);
	endtask

	// Hold the response side off long enough for the block to stall requests
	task automatic test_backpressure();
		int saved_send;
		int saved_recv;
		saved_send = send_idle_pct;
		saved_recv = recv_idle_pct;
		write_run_count(4'd8);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = 400;
		send_request(OP_CLEAR, 3'd0, 32'sd0);
		for (int i = 0; i < 40; i++)
			send_request(OP_APPEND, CID_W'(i % CHUNKS), 32'(i * 5 - 100));
		repeat (41) send_request(OP_TAKE, 3'd0, 32'sd0);
		send_idle_pct = saved_send;
		recv_idle_pct = saved_recv;
	endtask

	// Random merge rounds with some noise in between
	task automatic test_random_merges(input int send_pct, input int recv_pct,
			input int n_items);
		int                      stop_at;
		int unsigned             live;
		int                      n_app;
		int                      n_take;
		logic [CID_W-1:0]        id;
		logic [CCNT_W-1:0]       cnt;
		logic signed [VAL_W-1:0] tail [CHUNKS];
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at       = accepted_requests + n_items;
		while (accepted_requests < stop_at) begin
			// move to another run count now and then, mostly a legal one
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 3) == 0)
					cnt = CCNT_W'($urandom_range(0, 15));
				else
					cnt = CCNT_W'($urandom_range(1, CHUNKS));
				write_run_count(cnt);
			end
			live = (run_count < CHUNKS) ? run_count : CHUNKS;
			if ($urandom_range(0, 9) == 0) begin
				// noise: any op, any run, any value
				repeat ($urandom_range(1, 5))
					send_request(OP_W'($urandom_range(0, 3)), CID_W'($urandom_range(0, 7)),
						$urandom());
			end else begin
				// ascending runs, small steps so heads often tie
				for (int c = 0; c < CHUNKS; c++)
					tail[c] = $urandom_range(0, 1) ? $signed($urandom_range(0, 40)) - 20
						: $signed($urandom()) >>> 2;
				send_request(OP_CLEAR, CID_W'($urandom_range(0, 7)), $urandom());
				n_app = $urandom_range(1, 24);
				repeat (n_app) begin
					if (live == 0 || $urandom_range(0, 15) == 0)
						id = CID_W'($urandom_range(0, 7));
					else
						id = CID_W'($urandom_range(0, live - 1));
					tail[id] = tail[id] + $urandom_range(0, 3);
					send_request(OP_APPEND, id, tail[id]);
				end
				n_take = n_app + $urandom_range(0, 2);
				repeat (n_take) begin
					if (live != 0 && $urandom_range(0, 11) == 0) begin
						id       = CID_W'($urandom_range(0, live - 1));
						tail[id] = tail[id] + $urandom_range(0, 3);
						send_request(OP_APPEND, id, tail[id]);
					end
					send_request(OP_TAKE, CID_W'($urandom_range(0, 7)), $urandom());
				end
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 4'd1;
		run_count         = 4'd1;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_CLEAR;
		req_ch.chunk_id   = '0;
		req_ch.value      = '0;
		send_idle_pct     = 10;
		recv_idle_pct     = 30;
		hold_left         = 0;
		accepted_requests = 0;
		merged_values     = 0;
		refused_appends   = 0;
		exhausted_takes   = 0;
		count_writes      = 0;
		for (int c = 0; c < CHUNKS; c++) begin
			fill_level[c] = 0;
			take_pos[c]   = 0;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_extremes();
		test_run_count_edges();
		test_full_run();
		test_backpressure();
		test_random_merges(10, 59, 320);
		test_random_merges(59, 10, 320);
		test_random_merges(0, 0, 320);

		// drain the remaining responses
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4 * SCAN_CYCLES) @(negedge clk);

		$display("tb: %0d requests, %0d responses checked, %0d run count writes",
			accepted_requests, results_checked, count_writes);
		$display("tb: %0d merged values, %0d refused appends, %0d exhausted takes",
			merged_values, refused_appends, exhausted_takes);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
